### rtl/pbv_pkg.sv
// pbv_pkg: shared types and constants of the packet batch validator
// no dependencies; used by every module under rtl
package pbv_pkg;

   // build-time limits
   localparam logic [15:0] MAX_PACKETS           = 16'd64;
   localparam logic [15:0] MIN_PACKET_SIZE       = 16'd20;
   localparam logic [16:0] MAX_PACKET_SIZE       = 17'd65535;
   localparam logic [15:0] MAX_PACKET_SIZE_RESET = 16'hFFFF;

   // stream geometry
   localparam logic [31:0] HEADER_BYTES = 32'd8;
   localparam logic [31:0] POS_MAX      = 32'hFFFF_FFFF;
   localparam logic [32:0] OFFSET_MAX   = {33{1'b1}};

   // queue between front and back (depth of two or more)
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // what a byte is, as the front sees it
   typedef enum logic [1:0] {
      KIND_SKIP   = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_DESC   = 2'd2
   } kind_type;

   // result codes
   typedef enum logic [1:0] {
      STATUS_VALID       = 2'd0,
      STATUS_INVALID_ARG = 2'd1,
      STATUS_BAD_BATCH   = 2'd2
   } status_type;

   // one classified byte on its way from front to back
   typedef struct packed {
      logic [7:0]  data;
      kind_type    kind;
      logic [2:0]  idx;           // header byte or descriptor byte index
      logic        viol;          // violation found by the front
      logic        last;
      logic        short_stream;  // header or descriptors incomplete at last
      logic [31:0] position;      // byte count after this word
   } entry_type;

endpackage

### rtl/pbv_front.sv
// pbv_front: accepts payload words, tracks position and descriptor walk,
// and classifies each word for the back end; uses pbv_pkg
module pbv_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   input  logic               q_full,
   output logic               q_push,
   output pbv_pkg::entry_type q_entry
);

   logic [31:0] pos_ff, pos_in;
   logic [15:0] count_ff, count_in;
   logic [2:0]  shift_ff, shift_in;
   logic [15:0] desc_num_ff, desc_num_in;
   logic [15:0] count_hi;

   // accept whenever the queue has room
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign count_hi  = {req_data_byte, count_ff[7:0]};

   // classify the word and advance the walk
   always_comb begin
      pos_in      = pos_ff;
      count_in    = count_ff;
      shift_in    = shift_ff;
      desc_num_in = desc_num_ff;
      q_entry              = '0;
      q_entry.data         = req_data_byte;
      q_entry.kind         = pbv_pkg::KIND_SKIP;
      q_entry.last         = req_last_byte;
      if (pos_ff == pbv_pkg::POS_MAX) begin
         q_entry.viol = 1'b1;
      end else begin
         pos_in = pos_ff + 32'd1;
         if (pos_ff < pbv_pkg::HEADER_BYTES) begin
            q_entry.kind = pbv_pkg::KIND_HEADER;
            q_entry.idx  = pos_ff[2:0];
            case (pos_ff[2:0])
               3'd0: begin
                  count_in = {8'h00, req_data_byte};
               end
               3'd1: begin
                  count_in     = count_hi;
                  q_entry.viol = (count_hi == 16'd0) || (count_hi > pbv_pkg::MAX_PACKETS);
               end
               3'd2, 3'd3: begin
                  q_entry.viol = (req_data_byte != 8'h00);
               end
               default: begin
               end
            endcase
         end else if (desc_num_ff < count_ff) begin
            q_entry.kind = pbv_pkg::KIND_DESC;
            q_entry.idx  = shift_ff;
            shift_in     = shift_ff + 3'd1;
            if (shift_ff == 3'd7) begin
               desc_num_in = desc_num_ff + 16'd1;
            end
         end
      end
      q_entry.position     = pos_in;
      q_entry.short_stream = (pos_in < pbv_pkg::HEADER_BYTES) || (desc_num_in != count_in);
   end

   // walk state, cleared after the last word
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         count_ff    <= '0;
         shift_ff    <= '0;
         desc_num_ff <= '0;
      end else if (q_push) begin
         if (req_last_byte) begin
            pos_ff      <= '0;
            count_ff    <= '0;
            shift_ff    <= '0;
            desc_num_ff <= '0;
         end else begin
            pos_ff      <= pos_in;
            count_ff    <= count_in;
            shift_ff    <= shift_in;
            desc_num_ff <= desc_num_in;
         end
      end
   end

endmodule

### rtl/pbv_queue.sv
// pbv_queue: short queue of classified words between front and back
// uses pbv_pkg for the entry type and depth
module pbv_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pbv_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output pbv_pkg::entry_type head_entry
);

   pbv_pkg::entry_type              slot_ff [pbv_pkg::Q_DEPTH];
   logic [pbv_pkg::Q_PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [pbv_pkg::Q_CNT_W-1:0]     cnt_ff;

   localparam logic [pbv_pkg::Q_PTR_W-1:0] PTR_LAST = pbv_pkg::Q_PTR_W'(pbv_pkg::Q_DEPTH - 1);
   localparam logic [pbv_pkg::Q_CNT_W-1:0] CNT_FULL = pbv_pkg::Q_CNT_W'(pbv_pkg::Q_DEPTH);

   assign full       = (cnt_ff == CNT_FULL);
   assign head_valid = (cnt_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // never past full, never written when full, never read when empty
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL) else $error("queue count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid)) else $error("queue pop while empty");

endmodule

### rtl/pbv_back.sv
// pbv_back: runs the header and descriptor checks on classified words,
// holds the size register and the result register; uses pbv_pkg
module pbv_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_data,
   input  logic               q_valid,
   input  pbv_pkg::entry_type q_entry,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_packet_count
);

   logic [15:0] max_size_ff;
   logic [15:0] count_ff, count_in;
   logic [31:0] desc_len_ff, desc_len_in;
   logic [32:0] offset_ff, offset_in;
   logic [31:0] held_ff, held_in;
   logic        viol_ff, viol_in;
   logic        rsp_valid_ff, rsp_valid_in;
   pbv_pkg::status_type status_ff, status_in;
   logic [6:0]  pcount_ff, pcount_in;
   logic [31:0] byte_ext;
   logic [4:0]  sh;
   logic [33:0] offset_sum;
   logic        finish;

   assign csr_ready = 1'b1;
   assign byte_ext  = {24'h000000, q_entry.data};
   assign sh        = {q_entry.idx[1:0], 3'b000};

   // a last word waits until the result register is free
   assign q_pop  = q_valid && (!q_entry.last || !rsp_valid_ff || !rsp_stall);
   assign finish = q_pop && q_entry.last;

   // checks for one word
   always_comb begin
      count_in    = count_ff;
      desc_len_in = desc_len_ff;
      offset_in   = offset_ff;
      held_in     = held_ff;
      viol_in     = viol_ff | q_entry.viol;
      offset_sum  = '0;
      case (q_entry.kind)
         pbv_pkg::KIND_HEADER: begin
            case (q_entry.idx)
               3'd0: count_in = {8'h00, q_entry.data};
               3'd1: count_in = {q_entry.data, count_ff[7:0]};
               3'd4: desc_len_in = byte_ext;
               3'd5, 3'd6: desc_len_in = desc_len_ff | (byte_ext << sh);
               3'd7: begin
                  desc_len_in = desc_len_ff | (byte_ext << sh);
                  if (desc_len_in != {13'h0000, count_ff, 3'b000}) begin
                     viol_in = 1'b1;
                  end
                  offset_in = 33'd8 + {1'b0, desc_len_in};
               end
               default: begin
               end
            endcase
         end
         pbv_pkg::KIND_DESC: begin
            held_in = (q_entry.idx[1:0] == 2'd0) ? byte_ext : held_ff | (byte_ext << sh);
            if (q_entry.idx == 3'd3) begin
               if ({1'b0, held_in} != offset_ff) begin
                  viol_in = 1'b1;
               end
            end else if (q_entry.idx == 3'd7) begin
               if (held_in < {16'h0000, pbv_pkg::MIN_PACKET_SIZE} ||
                   held_in > {16'h0000, max_size_ff}) begin
                  viol_in = 1'b1;
               end
               offset_sum = {1'b0, offset_ff} + {2'b00, held_in};
               offset_in  = offset_sum[33] ? pbv_pkg::OFFSET_MAX : offset_sum[32:0];
            end
         end
         default: begin
         end
      endcase
   end

   // verdict at the last word
   always_comb begin
      status_in = pbv_pkg::STATUS_VALID;
      pcount_in = count_in[6:0];
      if (max_size_ff < pbv_pkg::MIN_PACKET_SIZE ||
          {1'b0, max_size_ff} > pbv_pkg::MAX_PACKET_SIZE) begin
         status_in = pbv_pkg::STATUS_INVALID_ARG;
         pcount_in = '0;
      end else if (viol_in || q_entry.short_stream ||
                   offset_in != {1'b0, q_entry.position}) begin
         status_in = pbv_pkg::STATUS_BAD_BATCH;
         pcount_in = '0;
      end
   end

   // result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   // size register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= pbv_pkg::MAX_PACKET_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         max_size_ff <= csr_data;
      end
   end

   // check state, cleared after the last word
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         desc_len_ff <= '0;
         offset_ff   <= '0;
         held_ff     <= '0;
         viol_ff     <= 1'b0;
      end else if (q_pop) begin
         if (q_entry.last) begin
            count_ff    <= '0;
            desc_len_ff <= '0;
            offset_ff   <= '0;
            held_ff     <= '0;
            viol_ff     <= 1'b0;
         end else begin
            count_ff    <= count_in;
            desc_len_ff <= desc_len_in;
            offset_ff   <= offset_in;
            held_ff     <= held_in;
            viol_ff     <= viol_in;
         end
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         status_ff <= status_in;
         pcount_ff <= pcount_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_packet_count = pcount_ff;

   // a good batch carries a count in range, any other carries zero
   a_good_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == pbv_pkg::STATUS_VALID) |->
      (pcount_ff != 7'd0 && {9'h000, pcount_ff} <= pbv_pkg::MAX_PACKETS))
      else $error("good batch with count out of range");
   a_bad_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != pbv_pkg::STATUS_VALID) |-> pcount_ff == 7'd0)
      else $error("failed batch with nonzero count");
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      finish |=> (!viol_ff && offset_ff == '0 && count_ff == '0))
      else $error("check state not cleared after last word");

endmodule

### rtl/packet_batch_validator_top.sv
// packet_batch_validator_top: streaming packet-batch payload checker
// depends on pbv_pkg, pbv_front, pbv_queue and pbv_back
//
//   channel | handshake             | fields                        | dir
//   req     | req_valid req_stall   | req_data_byte req_last_byte   | in
//   rsp     | rsp_valid rsp_stall   | rsp_status rsp_packet_count   | out
//   csr     | csr_valid csr_ready   | csr_data                      | in
//
// one payload word per cycle while req_stall is low; the result register loads when
// the back end pops the last word from the queue, after any words queued ahead of it
// reset is synchronous and active high; the size register resets to 65535
// a stalled result holds back only the last word of the next payload; other
// words keep flowing, and the two-entry queue stalls req when it fills
// csr_ready is always high; write the register only while the block is idle
module packet_batch_validator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_packet_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic               q_full, q_push, q_pop, q_valid;
   pbv_pkg::entry_type push_entry, head_entry;

   // classify incoming words
   pbv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   // decouple front and back
   pbv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   // checks and result
   pbv_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .q_valid          (q_valid),
      .q_entry          (head_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_packet_count (rsp_packet_count)
   );

endmodule

### verif/tb.sv
// tb: self-checking bench for packet_batch_validator_top, byte stream in, verdict out
// depends on rtl/pbv_pkg.sv and the rtl under packet_batch_validator_top
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 300;
   localparam int REPORT_MAX    = 10;
   localparam int DIRECTED_ROWS = 21;

   // expected verdict for one payload
   typedef struct packed {
      pbv_pkg::status_type status;
      logic [6:0]          pkts;
   } verdict_type;

   // one directed payload: size limit, header fields, descriptor shape, body shape, cut point, verdict
   typedef struct packed {
      logic [15:0]         max_size;
      logic [15:0]         count;
      logic [15:0]         resv;
      logic [31:0]         dlen;
      logic [7:0]          ndesc;
      logic [31:0]         plen;
      logic [31:0]         skew;
      logic signed [7:0]   tail_adj;
      logic                no_body;
      logic [15:0]         keep;
      logic                typed;
      pbv_pkg::status_type status;
      logic [6:0]          pkts;
   } batch_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_packet_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = 16'h0000;

   packet_batch_validator_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_packet_count (rsp_packet_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // validator shadow state
   logic [15:0] size_limit;
   logic [31:0] seen_bytes;
   logic [2:0]  desc_lane;
   logic [15:0] hdr_count;
   logic [31:0] hdr_dlen;
   logic [32:0] expect_off;
   logic [31:0] field_acc;
   logic [15:0] descs_done;
   logic        batch_broken;

   verdict_type pending_verdicts [$];
   logic [7:0]  frame_bytes [$];
   int          mismatches = 0;
   int          cycle_count = 0;
   int          req_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          hold_ticket = 0;
   int          hold_seen = 0;
   int          hold_left = 0;

   batch_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      // one byte only: stream ends inside the header
      '{16'd65535, 16'd1, 16'h0000, 32'd8, 8'd1, 32'd20, 32'd0, 8'sd0, 1'b0, 16'd1,
        1'b1, pbv_pkg::STATUS_BAD_BATCH, 7'd0},
      // smallest good batch
      '{16'd65535, 16'd1, 16'h0000, 32'd8, 8'd1, 32'd20, 32'd0, 8'sd0, 1'b0, 16'd0,
        1'b1, pbv_pkg::STATUS_VALID, 7'd1},
      // packet one byte below the minimum
      '{16'd65535, 16'd1, 16'h0000, 32'd8, 8'd1, 32'd19, 32'd0, 8'sd0, 1'b0, 16'd0,
        1'b1, pbv_pkg::STATUS_BAD_BATCH, 7'd0},
      // reserved half-word set
      '{16'd65535, 16'd1, 16'hFFFF, 32'd8, 8'd1, 32'd20, 32'd0, 8'sd0, 1'b0, 16'd0,
        1'b1, pbv_pkg::STATUS_BAD_BATCH, 7'd0},
      // zero packet count, header only
      '{16'd65535, 16'd0, 16'h0000, 32'd0, 8'd0, 32'd20, 32'd0, 8'sd0, 1'b1, 16'd0,
        1'b1, pbv_pkg::STATUS_BAD_BATCH, 7'd0},
      // largest packet count, stream stops after two descriptors
      '{16'd65535, 16'd64, 16'h0000, 32'd512, 8'd2, 32'd20, 32'd0, 8'sd0, 1'b1, 16'd0,
        1'b1, pbv_pkg::STATUS_BAD_BATCH, 7'd0},
      // one packet too many, first descriptors still walked
      '{16'd65535, 16'd65, 16'h0000, 32'd520, 8'd2, 32'd20, 32'd0, 8'sd0, 1'b1, 16'd0,
        1'b1, pbv_pkg::STATUS_BAD_BATCH, 7'd0},
      // all-ones count and descriptor length, stream stops after header
      '{16'd65535, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 8'd0, 32'd20, 32'd0, 8'sd0, 1'b1,
        16'd0, 1'b1, pbv_pkg::STATUS_BAD_BATCH, 7'd0},
      // descriptor length disagrees with count
      '{16'd65535, 16'd1, 16'h0000, 32'd16, 8'd1, 32'd20, 32'd0, 8'sd0, 1'b0, 16'd0,
        1'b1, pbv_pkg::STATUS_BAD_BATCH, 7'd0},
      // first offset not contiguous
      '{16'd65535, 16'd1, 16'h0000, 32'd8, 8'd1, 32'd20, 32'd1, 8'sd0, 1'b0, 16'd0,
        1'b1, pbv_pkg::STATUS_BAD_BATCH, 7'd0},
      // one stray byte past the last packet
      '{16'd65535, 16'd1, 16'h0000, 32'd8, 8'd1, 32'd20, 32'd0, 8'sd1, 1'b0, 16'd0,
        1'b1, pbv_pkg::STATUS_BAD_BATCH, 7'd0},
      // stream cut inside the descriptors
      '{16'd65535, 16'd2, 16'h0000, 32'd16, 8'd2, 32'd20, 32'd0, 8'sd0, 1'b0, 16'd13,
        1'b1, pbv_pkg::STATUS_BAD_BATCH, 7'd0},
      // stream cut inside the header
      '{16'd65535, 16'd2, 16'h0000, 32'd16, 8'd2, 32'd20, 32'd0, 8'sd0, 1'b0, 16'd5,
        1'b1, pbv_pkg::STATUS_BAD_BATCH, 7'd0},
      // huge lengths push the running offset into saturation
      '{16'd65535, 16'd2, 16'h0000, 32'd16, 8'd2, 32'hFFFF_FFFF, 32'd0, 8'sd0, 1'b1, 16'd0,
        1'b1, pbv_pkg::STATUS_BAD_BATCH, 7'd0},
      // longest packet length at the top limit, body left out
      '{16'd65535, 16'd1, 16'h0000, 32'd8, 8'd1, 32'd65535, 32'd0, 8'sd0, 1'b1, 16'd0,
        1'b0, pbv_pkg::STATUS_VALID, 7'd0},
      // limit of zero rejects a good batch
      '{16'd0, 16'd1, 16'h0000, 32'd8, 8'd1, 32'd20, 32'd0, 8'sd0, 1'b0, 16'd0,
        1'b1, pbv_pkg::STATUS_INVALID_ARG, 7'd0},
      // limit just below the minimum wins over a short stream
      '{16'd19, 16'd1, 16'h0000, 32'd8, 8'd1, 32'd20, 32'd0, 8'sd0, 1'b0, 16'd3,
        1'b1, pbv_pkg::STATUS_INVALID_ARG, 7'd0},
      // limit at the minimum, packets exactly that long
      '{16'd20, 16'd2, 16'h0000, 32'd16, 8'd2, 32'd20, 32'd0, 8'sd0, 1'b0, 16'd0,
        1'b1, pbv_pkg::STATUS_VALID, 7'd2},
      // packet one byte over the limit
      '{16'd20, 16'd1, 16'h0000, 32'd8, 8'd1, 32'd21, 32'd0, 8'sd0, 1'b0, 16'd0,
        1'b1, pbv_pkg::STATUS_BAD_BATCH, 7'd0},
      // small limit, packet exactly at it
      '{16'd30, 16'd1, 16'h0000, 32'd8, 8'd1, 32'd30, 32'd0, 8'sd0, 1'b0, 16'd0,
        1'b0, pbv_pkg::STATUS_VALID, 7'd0},
      // over the limit and one body byte short
      '{16'd30, 16'd1, 16'h0000, 32'd8, 8'd1, 32'd31, 32'd0, -8'sd1, 1'b0, 16'd0,
        1'b0, pbv_pkg::STATUS_VALID, 7'd0}
   };

   task automatic clear_validator();
      seen_bytes   = '0;
      desc_lane    = '0;
      hdr_count    = '0;
      hdr_dlen     = '0;
      expect_off   = '0;
      field_acc    = '0;
      descs_done   = '0;
      batch_broken = 1'b0;
   endtask

   // advance the shadow validator by one byte; a verdict comes out on the last byte
   task automatic advance_validator(input logic [7:0] b, input logic fin,
                                    output bit has, output verdict_type v);
      logic [31:0] p;
      logic [2:0]  k;
      logic [33:0] sum;
      p   = seen_bytes;
      has = 1'b0;
      v   = '{pbv_pkg::STATUS_VALID, 7'd0};
      if (seen_bytes == pbv_pkg::POS_MAX) begin
         batch_broken = 1'b1;
      end else begin
         seen_bytes = seen_bytes + 32'd1;
         if (p < pbv_pkg::HEADER_BYTES) begin
            // header: count, reserved, descriptor length
            case (p[2:0])
               3'd0: hdr_count = {8'h00, b};
               3'd1: begin
                  hdr_count[15:8] = b;
                  if (hdr_count == 16'd0 || hdr_count > pbv_pkg::MAX_PACKETS)
                     batch_broken = 1'b1;
               end
               3'd2, 3'd3: begin
                  if (b != 8'h00)
                     batch_broken = 1'b1;
               end
               default: begin
                  hdr_dlen[8*p[1:0] +: 8] = b;
                  if (p[2:0] == 3'd7) begin
                     if (hdr_dlen != {13'd0, hdr_count, 3'd0})
                        batch_broken = 1'b1;
                     expect_off = {1'b0, pbv_pkg::HEADER_BYTES} + {1'b0, hdr_dlen};
                  end
               end
            endcase
         end else if (descs_done < hdr_count) begin
            // descriptor: offset word then length word
            k = desc_lane;
            if (k[1:0] == 2'd0)
               field_acc = {24'd0, b};
            else
               field_acc[8*k[1:0] +: 8] = b;
            if (k == 3'd3) begin
               if ({1'b0, field_acc} != expect_off)
                  batch_broken = 1'b1;
            end else if (k == 3'd7) begin
               if (field_acc < {16'd0, pbv_pkg::MIN_PACKET_SIZE} ||
                   field_acc > {16'd0, size_limit})
                  batch_broken = 1'b1;
               sum = {1'b0, expect_off} + {2'd0, field_acc};
               expect_off = (sum > {1'b0, pbv_pkg::OFFSET_MAX}) ? pbv_pkg::OFFSET_MAX
                                                                : sum[32:0];
               descs_done = descs_done + 16'd1;
            end
            desc_lane = k + 3'd1;
         end
      end
      if (fin) begin
         has = 1'b1;
         if (size_limit < pbv_pkg::MIN_PACKET_SIZE ||
             {1'b0, size_limit} > pbv_pkg::MAX_PACKET_SIZE)
            v.status = pbv_pkg::STATUS_INVALID_ARG;
         else if (batch_broken || seen_bytes < pbv_pkg::HEADER_BYTES ||
                  descs_done != hdr_count || expect_off != {1'b0, seen_bytes})
            v.status = pbv_pkg::STATUS_BAD_BATCH;
         else
            v = '{pbv_pkg::STATUS_VALID, hdr_count[6:0]};
         clear_validator();
      end
   endtask

   // offer one word, hold it until taken, then book its verdict if any
   task automatic send_word(input logic [7:0] b, input logic fin,
                            input bit typed, input verdict_type typed_v);
      bit          has;
      verdict_type v;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= fin;
      do @(posedge clock); while (req_stall);
      advance_validator(b, fin, has, v);
      if (has)
         pending_verdicts.push_back(typed ? typed_v : v);
   endtask

   task automatic send_frame(input bit typed, input verdict_type typed_v);
      for (int i = 0; i < frame_bytes.size(); i++)
         send_word(frame_bytes[i], i == frame_bytes.size() - 1, typed, typed_v);
   endtask

   // stop offering and wait for every outstanding verdict
   task automatic settle(input int extra);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_max_size(input logic [15:0] value);
      settle(SETTLE_CYCLES);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      size_limit = value;
   endtask

   task automatic push_le(input logic [31:0] value, input int nbytes);
      for (int i = 0; i < nbytes; i++)
         frame_bytes.push_back(value[8*i +: 8]);
   endtask

   // random packet length, mostly legal, sometimes on or just past a bound
   function automatic logic [31:0] pick_length();
      int r;
      int hi;
      r  = $urandom_range(99);
      hi = (size_limit < 16'd28) ? int'(size_limit) : 28;
      if (r < 5)
         return 32'd19;
      if (r < 10 && size_limit <= 16'd300)
         return {16'd0, size_limit};
      if (r < 14 && size_limit <= 16'd300)
         return {16'd0, size_limit} + 32'd1;
      return $urandom_range(hi, 20);
   endfunction

   // lay out header, descriptors and body; plen of zero draws each length
   task automatic frame_batch(input logic [15:0] count, input logic [15:0] resv,
                              input logic [31:0] dlen, input int ndesc,
                              input logic [31:0] plen, input logic [31:0] skew,
                              input int tail_adj, input bit no_body, input int keep);
      logic [31:0] off;
      logic [31:0] len;
      longint      body;
      frame_bytes.delete();
      push_le({16'd0, count}, 2);
      push_le({16'd0, resv}, 2);
      push_le(dlen, 4);
      off  = pbv_pkg::HEADER_BYTES + dlen + skew;
      body = 0;
      for (int i = 0; i < ndesc; i++) begin
         len = (plen != 32'd0) ? plen : pick_length();
         push_le(off, 4);
         push_le(len, 4);
         off  = off + len;
         body = body + len;
      end
      if (!no_body)
         repeat (body + tail_adj) frame_bytes.push_back(8'($urandom_range(255)));
      if (keep > 0)
         while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
   endtask

   // mostly good batches, some damaged, some pure noise
   task automatic random_frame();
      int r;
      int n;
      int idx;
      r = $urandom_range(99);
      if (r < 80) begin
         n = ($urandom_range(9) < 7) ? 1 : $urandom_range(4, 2);
         frame_batch(16'(n), 16'h0000, 32'(n * 8), n, 32'd0, 32'd0, 0, 1'b0, 0);
         if (r >= 62) begin
            idx = $urandom_range(frame_bytes.size() - 1);
            case ($urandom_range(2))
               0: frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(255, 1));
               1: while (frame_bytes.size() > idx + 1) void'(frame_bytes.pop_back());
               default: repeat ($urandom_range(3, 1))
                  frame_bytes.push_back(8'($urandom_range(255)));
            endcase
         end
      end else begin
         frame_bytes.delete();
         repeat ($urandom_range(12, 1)) frame_bytes.push_back(8'($urandom_range(255)));
      end
   endtask

   task automatic log_mismatch(input bit orphan, input verdict_type want);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
         if (orphan)
            $display("%0t: verdict with none pending: status %0d count %0d",
                     $time, rsp_status, rsp_packet_count);
         else
            $display("%0t: verdict mismatch: status exp %0d got %0d, count exp %0d got %0d",
                     $time, want.status, rsp_status, want.pkts, rsp_packet_count);
      end
   endtask

   // result side: compare each taken verdict, then pick the next stall
   always @(posedge clock) begin : rsp_side
      verdict_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_verdicts.size() == 0) begin
               log_mismatch(1'b1, '{pbv_pkg::STATUS_VALID, 7'd0});
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_status !== want.status || rsp_packet_count !== want.pkts)
                  log_mismatch(1'b0, want);
            end
         end
         // long hold-off on request from the stimulus side
         if (hold_seen != hold_ticket) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      batch_row_type row;
      int            phase_words;
      int            phase_frames;
      size_limit = pbv_pkg::MAX_PACKET_SIZE_RESET;
      clear_validator();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed batches
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_rows[i];
         if (row.max_size != size_limit)
            write_max_size(row.max_size);
         frame_batch(row.count, row.resv, row.dlen, int'(row.ndesc), row.plen, row.skew,
                     int'(row.tail_adj), row.no_body, int'(row.keep));
         send_frame(row.typed, '{row.status, row.pkts});
      end

      // random batches under each idling mix
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               write_max_size(16'd65535);
               req_idle_pct   = 0;
               rsp_stall_pct <= 0;
            end
            1: begin
               write_max_size(pbv_pkg::MIN_PACKET_SIZE);
               req_idle_pct   = 71;
               rsp_stall_pct <= 0;
            end
            2: begin
               write_max_size(16'($urandom_range(300, 21)));
               req_idle_pct   = 0;
               rsp_stall_pct <= 71;
            end
            default: begin
               write_max_size(16'd40);
               req_idle_pct   = 27;
               rsp_stall_pct <= 27;
            end
         endcase
         phase_words  = 0;
         phase_frames = 0;
         while (phase_words < 40 || phase_frames < 2) begin
            random_frame();
            send_frame(1'b0, '{pbv_pkg::STATUS_VALID, 7'd0});
            phase_words  += frame_bytes.size();
            phase_frames += 1;
            // after the first frame of each phase, the sender pauses until the block has answered everything
            if (phase_frames == 1)
               settle(0);
         end
      end

      // receiver holds off while short payloads keep coming
      settle(SETTLE_CYCLES);
      req_idle_pct   = 0;
      rsp_stall_pct <= 0;
      hold_ticket   <= hold_ticket + 1;
      repeat (12) begin
         frame_bytes.delete();
         repeat ($urandom_range(3, 1)) frame_bytes.push_back(8'($urandom_range(255)));
         send_frame(1'b0, '{pbv_pkg::STATUS_VALID, 7'd0});
      end

      settle(8);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
rtl/pbv_pkg.sv
rtl/pbv_front.sv
rtl/pbv_queue.sv
rtl/pbv_back.sv
rtl/packet_batch_validator_top.sv
verif/tb.sv
